FILE: rtl/cell_balance_controller_macros.svh
// assertion macros shared by the cell balance controller rtl
// included by files that check their own logic; no other dependencies
`ifndef CELL_BALANCE_CONTROLLER_MACROS_SVH
`define CELL_BALANCE_CONTROLLER_MACROS_SVH
`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define CBC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cbc check failed");
// antecedent implies consequent in the next cycle
`define CBC_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cbc check failed");
`else
`define CBC_ASSERT_IMP(label, clk, rst, ante, cons)
`define CBC_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/cbc_pkg.sv
// shared types and constants of the cell balance controller
// no dependencies; used by every module, the interfaces do not import it
package cbc_pkg;

   localparam int unsigned RSP_DEPTH = 4;

   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_MIN_CELL      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_DELTA   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STOP_DELTA    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REFRESH       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TEMP_MIN      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_TEMP_MAX      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_FAULT_MASK    = 3'd6;

   localparam logic [15:0]        MIN_CELL_RST    = 16'd3400;
   localparam logic [15:0]        START_DELTA_RST = 16'd30;
   localparam logic [15:0]        STOP_DELTA_RST  = 16'd10;
   localparam logic [31:0]        REFRESH_RST     = 32'd15000;
   localparam logic signed [15:0] TEMP_MIN_RST    = 16'sd0;
   localparam logic signed [15:0] TEMP_MAX_RST    = 16'sd450;
   localparam logic [31:0]        FAULT_MASK_RST  = 32'hFFFF_FFFF;

   // seeds of the temperature fold, they clamp the extremes
   localparam logic signed [15:0] TEMP_LO_SEED = 16'sd1000;
   localparam logic signed [15:0] TEMP_HI_SEED = -16'sd1000;

   localparam logic [2:0] MIN_VALID_TEMPS = 3'd3;

   localparam logic [1:0] GROUP_NONE = 2'd0;
   localparam logic [1:0] GROUP_A    = 2'd1;
   localparam logic [1:0] GROUP_B    = 2'd2;
   localparam logic [1:0] GROUP_C    = 2'd3;

   localparam int unsigned ST_MON_INIT = 3;

   typedef struct packed {
      logic [15:0]        cell_floor_mv;
      logic [15:0]        start_gap_mv;
      logic [15:0]        stop_gap_mv;
      logic [31:0]        refresh_period_ms;
      logic signed [15:0] temp_min_dc;
      logic signed [15:0] temp_max_dc;
      logic [31:0]        prohibit_fault_mask;
   } cfg_type;

   typedef struct packed {
      logic [4:0]         status_bits;
      logic [31:0]        fault_flags;
      logic [15:0]        cell_a_mv;
      logic [15:0]        cell_b_mv;
      logic [15:0]        cell_c_mv;
      logic [3:0]         temp_valid_bits;
      logic signed [15:0] temp_a_dc;
      logic signed [15:0] temp_b_dc;
      logic signed [15:0] temp_c_dc;
      logic signed [15:0] temp_center_dc;
      logic [31:0]        now_ms;
      logic               write_ok;
   } item_type;

   typedef struct packed {
      logic       command_valid;
      logic [1:0] command_group;
      logic       last_of_step;
      logic       balancing_on;
      logic [1:0] current_group;
      logic       allowed;
   } rsp_word_type;

   typedef struct packed {
      logic [1:0]   push_n;
      rsp_word_type word0;
      rsp_word_type word1;
      logic         next_active;
      logic [1:0]   next_group;
      logic         time_we;
   } decide_type;

endpackage

FILE: rtl/cbc_if.sv
// request and response channel interfaces of the cell balance controller
// depends on cbc_pkg for nothing but keeps field widths from the work item
interface cbc_req_if;
   logic               valid;
   logic               ready;
   logic [4:0]         status_bits;
   logic [31:0]        fault_flags;
   logic [15:0]        cell_a_mv;
   logic [15:0]        cell_b_mv;
   logic [15:0]        cell_c_mv;
   logic [3:0]         temp_valid_bits;
   logic signed [15:0] temp_a_dc;
   logic signed [15:0] temp_b_dc;
   logic signed [15:0] temp_c_dc;
   logic signed [15:0] temp_center_dc;
   logic [31:0]        now_ms;
   logic               write_ok;

   modport source (
      output valid, status_bits, fault_flags, cell_a_mv, cell_b_mv, cell_c_mv,
             temp_valid_bits, temp_a_dc, temp_b_dc, temp_c_dc, temp_center_dc,
             now_ms, write_ok,
      input  ready
   );
   modport sink (
      input  valid, status_bits, fault_flags, cell_a_mv, cell_b_mv, cell_c_mv,
             temp_valid_bits, temp_a_dc, temp_b_dc, temp_c_dc, temp_center_dc,
             now_ms, write_ok,
      output ready
   );
endinterface

interface cbc_rsp_if;
   logic       valid;
   logic       ready;
   logic       command_valid;
   logic [1:0] command_group;
   logic       last_of_step;
   logic       balancing_on;
   logic [1:0] current_group;
   logic       allowed;

   modport source (
      output valid, command_valid, command_group, last_of_step, balancing_on,
             current_group, allowed,
      input  ready
   );
   modport sink (
      input  valid, command_valid, command_group, last_of_step, balancing_on,
             current_group, allowed,
      output ready
   );
endinterface

FILE: rtl/cbc_eval.sv
// decision logic: permission checks, cell extremes and the off/active step
// depends on cbc_pkg; purely combinational, state lives in the top level
module cbc_eval import cbc_pkg::*; (
   input  cfg_type    cfg,
   input  item_type   item,
   input  logic       active,
   input  logic [1:0] group,
   input  logic [31:0] last_time,
   output decide_type dec
);

   logic signed [15:0] temps [4];
   logic signed [15:0] t_lo;
   logic signed [15:0] t_hi;
   logic [2:0]         t_cnt;
   logic               allow;
   logic [15:0]        c_lo;
   logic [15:0]        c_hi;
   logic [15:0]        c_delta;
   logic [15:0]        c_top;
   logic [1:0]         c_grp;
   logic               start_ok;
   logic               stop_now;
   logic               refresh_due;
   logic               clear_ok;
   logic [1:0]         cmd0;
   logic [1:0]         cmd1;
   logic [1:0]         n_cmd;
   logic               nxt_act;
   logic [1:0]         nxt_grp;
   logic               time_we;

   assign temps[0] = item.temp_a_dc;
   assign temps[1] = item.temp_b_dc;
   assign temps[2] = item.temp_c_dc;
   assign temps[3] = item.temp_center_dc;

   always_comb begin
      t_lo  = TEMP_LO_SEED;
      t_hi  = TEMP_HI_SEED;
      t_cnt = '0;
      for (int i = 0; i < 4; i++) begin
         if (item.temp_valid_bits[i]) begin
            t_cnt = t_cnt + 3'd1;
            if (temps[i] < t_lo) t_lo = temps[i];
            if (temps[i] > t_hi) t_hi = temps[i];
         end
      end
   end

   assign allow = (&item.status_bits)
                  && ((item.fault_flags & cfg.prohibit_fault_mask) == '0)
                  && (t_cnt >= MIN_VALID_TEMPS)
                  && !(t_lo < cfg.temp_min_dc)
                  && !(t_hi > cfg.temp_max_dc);

   always_comb begin
      c_lo  = item.cell_a_mv;
      c_hi  = item.cell_a_mv;
      c_top = item.cell_a_mv;
      c_grp = GROUP_A;
      if (item.cell_b_mv < c_lo) c_lo = item.cell_b_mv;
      if (item.cell_c_mv < c_lo) c_lo = item.cell_c_mv;
      if (item.cell_b_mv > c_hi) c_hi = item.cell_b_mv;
      if (item.cell_c_mv > c_hi) c_hi = item.cell_c_mv;
      // strict compare keeps the lower group on ties
      if (item.cell_b_mv > c_top) begin
         c_grp = GROUP_B;
         c_top = item.cell_b_mv;
      end
      if (item.cell_c_mv > c_top) c_grp = GROUP_C;
   end

   assign c_delta     = c_hi - c_lo;
   assign start_ok    = (c_lo >= cfg.cell_floor_mv) && (c_delta >= cfg.start_gap_mv);
   assign stop_now    = (c_lo < cfg.cell_floor_mv) || (c_delta <= cfg.stop_gap_mv);
   // wrapping elapsed time
   assign refresh_due = (item.now_ms - last_time) >= cfg.refresh_period_ms;
   assign clear_ok    = item.status_bits[ST_MON_INIT] && ((group != GROUP_NONE) || active);

   always_comb begin
      nxt_act = active;
      nxt_grp = group;
      time_we = 1'b0;
      n_cmd   = 2'd0;
      cmd0    = GROUP_NONE;
      cmd1    = GROUP_NONE;
      priority if (!allow) begin
         nxt_act = 1'b0;
         nxt_grp = GROUP_NONE;
         time_we = 1'b1;
         if (clear_ok) n_cmd = 2'd1;
      end else if (!active) begin
         if (start_ok) begin
            n_cmd = 2'd1;
            cmd0  = c_grp;
            if (item.write_ok) begin
               nxt_act = 1'b1;
               nxt_grp = c_grp;
               time_we = 1'b1;
            end
         end
      end else if (stop_now) begin
         nxt_act = 1'b0;
         nxt_grp = GROUP_NONE;
         time_we = 1'b1;
         if (clear_ok) n_cmd = 2'd1;
      end else if ((c_grp != group) || refresh_due) begin
         n_cmd   = 2'd1;
         cmd0    = c_grp;
         time_we = 1'b1;
         if (item.write_ok) begin
            nxt_grp = c_grp;
         end else begin
            // failed group change or refresh forces off, clear follows the group write
            nxt_act = 1'b0;
            nxt_grp = GROUP_NONE;
            if (clear_ok) n_cmd = 2'd2;
         end
      end else begin
         n_cmd = 2'd0;
      end
   end

   always_comb begin
      dec.next_active = nxt_act;
      dec.next_group  = nxt_grp;
      dec.time_we     = time_we;
      dec.push_n      = (n_cmd == 2'd0) ? 2'd1 : n_cmd;

      dec.word0.command_valid = (n_cmd != 2'd0);
      dec.word0.command_group = cmd0;
      dec.word0.last_of_step  = (n_cmd != 2'd2);
      dec.word0.balancing_on  = nxt_act;
      dec.word0.current_group = nxt_grp;
      dec.word0.allowed       = allow;

      dec.word1.command_valid = 1'b1;
      dec.word1.command_group = cmd1;
      dec.word1.last_of_step  = 1'b1;
      dec.word1.balancing_on  = nxt_act;
      dec.word1.current_group = nxt_grp;
      dec.word1.allowed       = allow;
   end

endmodule

FILE: rtl/cbc_rsp_fifo.sv
// result queue: takes one or two words per cycle, hands out one per cycle while the sink is ready
// depends on cbc_pkg, cbc_rsp_if and the assertion macro header
`include "cell_balance_controller_macros.svh"
module cbc_rsp_fifo import cbc_pkg::*; #(
   parameter int unsigned Depth = RSP_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic [1:0]   push_n,
   input  rsp_word_type word0,
   input  rsp_word_type word1,
   output logic         room_two,
   cbc_rsp_if.source    rsp
);

   localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] CntRoom = CntW'(Depth - 2);

   rsp_word_type    mem_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic [PtrW-1:0] wr_next;
   logic            pop;

   function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
      ptr_inc = (p == PtrLast) ? '0 : p + PtrW'(1);
   endfunction

   assign pop      = rsp.valid && rsp.ready;
   assign wr_next  = ptr_inc(wr_ptr_ff);
   assign room_two = (cnt_ff <= CntRoom);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      if (push_n == 2'd1) wr_ptr_in = wr_next;
      if (push_n == 2'd2) wr_ptr_in = ptr_inc(wr_next);
      rd_ptr_in = pop ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      cnt_in    = cnt_ff + CntW'(push_n) - CntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) mem_ff[wr_ptr_ff] <= word0;
      if (push_n == 2'd2) mem_ff[wr_next] <= word1;
   end

   assign rsp.valid         = (cnt_ff != '0);
   assign rsp.command_valid = mem_ff[rd_ptr_ff].command_valid;
   assign rsp.command_group = mem_ff[rd_ptr_ff].command_group;
   assign rsp.last_of_step  = mem_ff[rd_ptr_ff].last_of_step;
   assign rsp.balancing_on  = mem_ff[rd_ptr_ff].balancing_on;
   assign rsp.current_group = mem_ff[rd_ptr_ff].current_group;
   assign rsp.allowed       = mem_ff[rd_ptr_ff].allowed;

   `CBC_ASSERT_IMP(a_fifo_no_overflow, clock, reset, 1'b1, cnt_ff <= CntW'(Depth))
   `CBC_ASSERT_NXT(a_fifo_pair_count, clock, reset, (push_n == 2'd2) && !pop, cnt_ff == $past(cnt_ff) + CntW'(2))

endmodule

FILE: rtl/cell_balance_controller.sv
// Cell balance controller. Each accepted request word is one evaluation; it lands in an
// input register, the permission and balancing decision is made from that register once
// the queue has room for two words, and the one or two response words it causes go into
// a small result queue (RspDepth words). A request can be taken every cycle as long as
// the queue has room for two words, so with the response sink always ready the sustained
// rate is one evaluation per cycle when each yields one word, and lower when each yields
// two (the single response port sets that). The first response word passes through the
// input register and the result queue before it is offered. Settings on the csr port are
// registered and must only change while no evaluation is pending.
// depends on cbc_pkg, cbc_if, cbc_eval, cbc_rsp_fifo and the assertion macro header
`include "cell_balance_controller_macros.svh"
module cell_balance_controller import cbc_pkg::*; #(
   parameter int unsigned RspDepth = RSP_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   cbc_req_if.sink               req,
   cbc_rsp_if.source             rsp
);

   typedef enum logic {ST_OFF, ST_ACTIVE} bal_state_type;

   cfg_type       cfg_ff;
   item_type      item_ff;
   logic          item_vld_ff, item_vld_in;
   bal_state_type state_ff, state_in;
   logic [1:0]    group_ff, group_in;
   logic [31:0]   time_ff, time_in;
   decide_type    dec;
   logic          room_two;
   logic          process;
   logic          take;
   logic [1:0]    push_n;

   // an evaluation goes out when the queue can hold both possible words
   assign process   = item_vld_ff && room_two;
   assign req.ready = !item_vld_ff || process;
   assign take      = req.valid && req.ready;
   assign push_n    = process ? dec.push_n : 2'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cell_floor_mv       <= MIN_CELL_RST;
         cfg_ff.start_gap_mv        <= START_DELTA_RST;
         cfg_ff.stop_gap_mv         <= STOP_DELTA_RST;
         cfg_ff.refresh_period_ms   <= REFRESH_RST;
         cfg_ff.temp_min_dc         <= TEMP_MIN_RST;
         cfg_ff.temp_max_dc         <= TEMP_MAX_RST;
         cfg_ff.prohibit_fault_mask <= FAULT_MASK_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MIN_CELL:    cfg_ff.cell_floor_mv       <= csr_wdata[15:0];
            CSR_START_DELTA: cfg_ff.start_gap_mv        <= csr_wdata[15:0];
            CSR_STOP_DELTA:  cfg_ff.stop_gap_mv         <= csr_wdata[15:0];
            CSR_REFRESH:     cfg_ff.refresh_period_ms   <= csr_wdata[31:0];
            CSR_TEMP_MIN:    cfg_ff.temp_min_dc         <= csr_wdata[15:0];
            CSR_TEMP_MAX:    cfg_ff.temp_max_dc         <= csr_wdata[15:0];
            CSR_FAULT_MASK:  cfg_ff.prohibit_fault_mask <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   assign item_vld_in = take || (item_vld_ff && !process);

   always_ff @(posedge clock) begin
      if (reset) begin
         item_vld_ff <= 1'b0;
      end else begin
         item_vld_ff <= item_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.status_bits     <= req.status_bits;
         item_ff.fault_flags     <= req.fault_flags;
         item_ff.cell_a_mv       <= req.cell_a_mv;
         item_ff.cell_b_mv       <= req.cell_b_mv;
         item_ff.cell_c_mv       <= req.cell_c_mv;
         item_ff.temp_valid_bits <= req.temp_valid_bits;
         item_ff.temp_a_dc       <= req.temp_a_dc;
         item_ff.temp_b_dc       <= req.temp_b_dc;
         item_ff.temp_c_dc       <= req.temp_c_dc;
         item_ff.temp_center_dc  <= req.temp_center_dc;
         item_ff.now_ms          <= req.now_ms;
         item_ff.write_ok        <= req.write_ok;
      end
   end

   cbc_eval u_eval (
      .cfg       (cfg_ff),
      .item      (item_ff),
      .active    (state_ff == ST_ACTIVE),
      .group     (group_ff),
      .last_time (time_ff),
      .dec       (dec)
   );

   always_comb begin
      state_in = state_ff;
      group_in = group_ff;
      time_in  = time_ff;
      if (process) begin
         state_in = dec.next_active ? ST_ACTIVE : ST_OFF;
         group_in = dec.next_group;
         if (dec.time_we) time_in = item_ff.now_ms;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_OFF;
         group_ff <= GROUP_NONE;
         time_ff  <= '0;
      end else begin
         state_ff <= state_in;
         group_ff <= group_in;
         time_ff  <= time_in;
      end
   end

   cbc_rsp_fifo #(
      .Depth (RspDepth)
   ) u_rsp_fifo (
      .clock    (clock),
      .reset    (reset),
      .push_n   (push_n),
      .word0    (dec.word0),
      .word1    (dec.word1),
      .room_two (room_two),
      .rsp      (rsp)
   );

   `CBC_ASSERT_IMP(a_group_tracks_state, clock, reset, 1'b1, (state_ff == ST_OFF) == (group_ff == GROUP_NONE))
   `CBC_ASSERT_NXT(a_off_stamps_time, clock, reset, process && (state_ff == ST_ACTIVE) && !dec.next_active, time_ff == $past(item_ff.now_ms))

endmodule
